/* src/md5_pkg.sv */
package md5_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
  } md5_out_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  nbytes;
    logic        last;
  } md5_item_t;

  typedef struct packed {
    logic      vld;
    md5_item_t item;
  } md5_qhead_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_BYTE = 6'b000010,
    S_LOAD = 6'b000100,
    S_COMP = 6'b001000,
    S_ADD  = 6'b010000,
    S_OUT  = 6'b100000
  } md5_state_t;

  typedef enum logic [3:0] {
    SRC_DATA  = 4'b0001,
    SRC_PAD80 = 4'b0010,
    SRC_ZERO  = 4'b0100,
    SRC_LEN   = 4'b1000
  } md5_src_t;

  localparam logic [1:0] PH_F = 2'd0;
  localparam logic [1:0] PH_G = 2'd1;
  localparam logic [1:0] PH_H = 2'd2;

  localparam logic [2:0] MAX_BYTES = 3'd4;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;

  localparam logic [3:0][31:0] MD5_IV = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  function automatic logic [3:0] md5_msg_idx(input logic [5:0] s);
    logic [3:0] j;
    j = s[3:0];
    case (s[5:4])
      PH_F: return j;
      PH_G: return 4'(j * 4'd5 + 4'd1);
      PH_H: return 4'(j * 4'd3 + 4'd5);
      default: return 4'(j * 4'd7);
    endcase
  endfunction

  function automatic logic [4:0] md5_rot_amt(input logic [3:0] sel);
    case (sel)
      4'd0:  return 5'd7;
      4'd1:  return 5'd12;
      4'd2:  return 5'd17;
      4'd3:  return 5'd22;
      4'd4:  return 5'd5;
      4'd5:  return 5'd9;
      4'd6:  return 5'd14;
      4'd7:  return 5'd20;
      4'd8:  return 5'd4;
      4'd9:  return 5'd11;
      4'd10: return 5'd16;
      4'd11: return 5'd23;
      4'd12: return 5'd6;
      4'd13: return 5'd10;
      4'd14: return 5'd15;
      default: return 5'd21;
    endcase
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] md5_round_const(input logic [5:0] s);
    case (s)
      6'd0:  return 32'hd76aa478;
      6'd1:  return 32'he8c7b756;
      6'd2:  return 32'h242070db;
      6'd3:  return 32'hc1bdceee;
      6'd4:  return 32'hf57c0faf;
      6'd5:  return 32'h4787c62a;
      6'd6:  return 32'ha8304613;
      6'd7:  return 32'hfd469501;
      6'd8:  return 32'h698098d8;
      6'd9:  return 32'h8b44f7af;
      6'd10: return 32'hffff5bb1;
      6'd11: return 32'h895cd7be;
      6'd12: return 32'h6b901122;
      6'd13: return 32'hfd987193;
      6'd14: return 32'ha679438e;
      6'd15: return 32'h49b40821;
      6'd16: return 32'hf61e2562;
      6'd17: return 32'hc040b340;
      6'd18: return 32'h265e5a51;
      6'd19: return 32'he9b6c7aa;
      6'd20: return 32'hd62f105d;
      6'd21: return 32'h02441453;
      6'd22: return 32'hd8a1e681;
      6'd23: return 32'he7d3fbc8;
      6'd24: return 32'h21e1cde6;
      6'd25: return 32'hc33707d6;
      6'd26: return 32'hf4d50d87;
      6'd27: return 32'h455a14ed;
      6'd28: return 32'ha9e3e905;
      6'd29: return 32'hfcefa3f8;
      6'd30: return 32'h676f02d9;
      6'd31: return 32'h8d2a4c8a;
      6'd32: return 32'hfffa3942;
      6'd33: return 32'h8771f681;
      6'd34: return 32'h6d9d6122;
      6'd35: return 32'hfde5380c;
      6'd36: return 32'ha4beea44;
      6'd37: return 32'h4bdecfa9;
      6'd38: return 32'hf6bb4b60;
      6'd39: return 32'hbebfbc70;
      6'd40: return 32'h289b7ec6;
      6'd41: return 32'heaa127fa;
      6'd42: return 32'hd4ef3085;
      6'd43: return 32'h04881d05;
      6'd44: return 32'hd9d4d039;
      6'd45: return 32'he6db99e5;
      6'd46: return 32'h1fa27cf8;
      6'd47: return 32'hc4ac5665;
      6'd48: return 32'hf4292244;
      6'd49: return 32'h432aff97;
      6'd50: return 32'hab9423a7;
      6'd51: return 32'hfc93a039;
      6'd52: return 32'h655b59c3;
      6'd53: return 32'h8f0ccc92;
      6'd54: return 32'hffeff47d;
      6'd55: return 32'h85845dd1;
      6'd56: return 32'h6fa87e4f;
      6'd57: return 32'hfe2ce6e0;
      6'd58: return 32'ha3014314;
      6'd59: return 32'h4e0811a1;
      6'd60: return 32'hf7537e82;
      6'd61: return 32'hbd3af235;
      6'd62: return 32'h2ad7d2bb;
      default: return 32'heb86d391;
    endcase
  endfunction

endpackage

/* src/md5_hash_engine_top.sv */
// Channel  Ports                        Transfer when
// input    in_data, in_push, in_full    in_push && !in_full
// result   out_data, out_empty, out_pop out_pop && !out_empty
//
// The back end packs one byte per cycle into the block buffer, except while it
// fetches an item from the queue or compresses a block (load, 64 rounds, chain
// add) for every 64 bytes, and while it holds a digest.
// The last word adds padding (0x80, zeros, 64-bit length) and one compression or two.
// A two-entry queue takes input items while the back end compresses or
// holds a digest. Reset (rst_n low at a clock edge) restores the initial value.
module md5_hash_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  md5_pkg::md5_in_t    in_data,
  input  logic                in_push,
  output logic                in_full,
  output md5_pkg::md5_out_t   out_data,
  output logic                out_empty,
  input  logic                out_pop
);

  md5_pkg::md5_qhead_t head;
  logic                pop;

  md5_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .in_push (in_push),
    .in_full (in_full),
    .head_o  (head),
    .pop_i   (pop)
  );

  md5_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_i    (head),
    .pop_o     (pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

/* src/md5_front.sv */
module md5_front (
  input  logic                clk,
  input  logic                rst_n,
  input  md5_pkg::md5_in_t    in_data,
  input  logic                in_push,
  output logic                in_full,
  output md5_pkg::md5_qhead_t head_o,
  input  logic                pop_i
);

  md5_pkg::md5_item_t q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en;
  logic       rd_en;
  md5_pkg::md5_item_t item;

  always_comb begin
    item.data_word = in_data.data_word;
    item.last      = in_data.last_word;
    item.nbytes    = (in_data.valid_bytes > md5_pkg::MAX_BYTES) ? md5_pkg::MAX_BYTES
                                                                 : in_data.valid_bytes;
  end

  assign in_full     = (cnt_r == 2'd2);
  assign wr_en       = in_push && !in_full;
  assign rd_en       = pop_i && (cnt_r != 2'd0);
  assign head_o.vld  = (cnt_r != 2'd0);
  assign head_o.item = q_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r ^ wr_en;
    rd_nxt  = rd_r ^ rd_en;
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_r] <= item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("front queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (cnt_r != 2'd0))
    else $error("pop from empty front queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("front queue lost a transfer");

endmodule

/* src/md5_core.sv */
module md5_core (
  input  logic                clk,
  input  logic                rst_n,
  input  md5_pkg::md5_qhead_t head_i,
  output logic                pop_o,
  output md5_pkg::md5_out_t   out_data,
  output logic                out_empty,
  input  logic                out_pop
);

  md5_pkg::md5_state_t state_r, state_nxt;
  md5_pkg::md5_src_t   src_r, src_nxt;

  logic [31:0] word_r;
  logic [2:0]  nb_r;
  logic        last_r;
  logic [2:0]  idx_r, idx_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] blen_r, blen_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  logic [31:0] buf_r [16];
  logic [3:0][31:0] chain_r, chain_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] pre_r, pre_nxt;

  logic        item_ld;
  logic        put;
  logic [7:0]  pbyte;
  logic [5:0]  nstep;
  logic [31:0] f;
  logic [31:0] t;

  always_comb begin
    case (step_r[5:4])
      md5_pkg::PH_F: f = (b_r & c_r) | (~b_r & d_r);
      md5_pkg::PH_G: f = (b_r & d_r) | (c_r & ~d_r);
      md5_pkg::PH_H: f = b_r ^ c_r ^ d_r;
      default:       f = c_r ^ (b_r | ~d_r);
    endcase
    t = f + a_r + pre_r;
  end

  assign nstep   = (state_r == md5_pkg::S_LOAD) ? 6'd0 : step_r + 6'd1;
  assign pre_nxt = buf_r[md5_pkg::md5_msg_idx(nstep)] + md5_pkg::md5_round_const(nstep);

  always_comb begin
    state_nxt = state_r;
    src_nxt   = src_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    blen_nxt  = blen_r;
    step_nxt  = step_r;
    oidx_nxt  = oidx_r;
    chain_nxt = chain_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    pop_o     = 1'b0;
    item_ld   = 1'b0;
    put       = 1'b0;
    pbyte     = 8'h00;
    case (state_r)
      md5_pkg::S_IDLE: begin
        if (head_i.vld) begin
          pop_o     = 1'b1;
          item_ld   = 1'b1;
          idx_nxt   = 3'd0;
          src_nxt   = md5_pkg::SRC_DATA;
          state_nxt = md5_pkg::S_BYTE;
        end
      end
      md5_pkg::S_BYTE: begin
        case (src_r)
          md5_pkg::SRC_DATA: begin
            if (idx_r < nb_r) begin
              put      = 1'b1;
              pbyte    = word_r[{idx_r[1:0], 3'b000} +: 8];
              idx_nxt  = idx_r + 3'd1;
              blen_nxt = blen_r + 64'd8;
            end
            if (idx_nxt >= nb_r) begin
              if (last_r) begin
                src_nxt = md5_pkg::SRC_PAD80;
              end else begin
                state_nxt = md5_pkg::S_IDLE;
              end
            end
          end
          md5_pkg::SRC_PAD80: begin
            put     = 1'b1;
            pbyte   = md5_pkg::PAD_BYTE;
            src_nxt = md5_pkg::SRC_ZERO;
          end
          md5_pkg::SRC_ZERO: begin
            if (pos_r == md5_pkg::LEN_POS) begin
              src_nxt = md5_pkg::SRC_LEN;
            end else begin
              put = 1'b1;
            end
          end
          md5_pkg::SRC_LEN: begin
            put   = 1'b1;
            pbyte = blen_r[{pos_r[2:0], 3'b000} +: 8];
          end
          default: ;
        endcase
        if (put) begin
          pos_nxt = pos_r + 6'd1;
          if (&pos_r) begin
            state_nxt = md5_pkg::S_LOAD;
          end
        end
      end
      md5_pkg::S_LOAD: begin
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        step_nxt  = 6'd0;
        state_nxt = md5_pkg::S_COMP;
      end
      md5_pkg::S_COMP: begin
        a_nxt    = d_r;
        d_nxt    = c_r;
        c_nxt    = b_r;
        b_nxt    = b_r + md5_pkg::md5_rotl(t, md5_pkg::md5_rot_amt({step_r[5:4], step_r[1:0]}));
        step_nxt = step_r + 6'd1;
        if (&step_r) begin
          state_nxt = md5_pkg::S_ADD;
        end
      end
      md5_pkg::S_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        state_nxt    = (src_r == md5_pkg::SRC_LEN) ? md5_pkg::S_OUT : md5_pkg::S_BYTE;
      end
      md5_pkg::S_OUT: begin
        if (out_pop) begin
          oidx_nxt = oidx_r + 2'd1;
          if (&oidx_r) begin
            chain_nxt = md5_pkg::MD5_IV;
            blen_nxt  = 64'd0;
            state_nxt = md5_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = md5_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5_pkg::S_IDLE;
      src_r   <= md5_pkg::SRC_DATA;
      idx_r   <= 3'd0;
      pos_r   <= 6'd0;
      blen_r  <= 64'd0;
      step_r  <= 6'd0;
      oidx_r  <= 2'd0;
      chain_r <= md5_pkg::MD5_IV;
    end else begin
      state_r <= state_nxt;
      src_r   <= src_nxt;
      idx_r   <= idx_nxt;
      pos_r   <= pos_nxt;
      blen_r  <= blen_nxt;
      step_r  <= step_nxt;
      oidx_r  <= oidx_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    pre_r <= pre_nxt;
    if (item_ld) begin
      word_r <= head_i.item.data_word;
      nb_r   <= head_i.item.nbytes;
      last_r <= head_i.item.last;
    end
    if (put) begin
      buf_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] <= pbyte;
    end
  end

  assign out_empty            = (state_r != md5_pkg::S_OUT);
  assign out_data.digest_word = chain_r[oidx_r];
  assign out_data.word_index  = oidx_r;
  assign out_data.digest_last = &oidx_r;

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::S_LOAD) |=> (state_r == md5_pkg::S_COMP && step_r == 6'd0))
    else $error("compression did not start at step zero");

  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::S_COMP || state_r == md5_pkg::S_ADD) |-> (pos_r == 6'd0))
    else $error("compression on a partial block");

  a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::S_OUT && out_pop && oidx_r == 2'd3)
      |=> (state_r == md5_pkg::S_IDLE && blen_r == 64'd0))
    else $error("no restart after final digest word");

  a_out_from_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == md5_pkg::S_OUT) |-> (src_r == md5_pkg::SRC_LEN && oidx_r == 2'd0))
    else $error("digest shown before length block");

endmodule

/* tb/tb_md5_hash_engine_top.sv */
module tb_md5_hash_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 250;
  localparam int HOLD_CYCLES = 500;

  localparam logic [0:63][31:0] ROUND_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [0:15][4:0] ROT_AMT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  md5_pkg::md5_in_t  in_data = '0;
  logic              in_push = 1'b0;
  logic              in_full;
  md5_pkg::md5_out_t out_data;
  logic              out_empty;
  logic              out_pop = 1'b0;

  md5_pkg::md5_in_t  msg_q[$];
  md5_pkg::md5_out_t digest_q[$];

  logic [31:0] chain[4];
  logic [31:0] blk_buf[16];
  logic [63:0] msg_bits;
  logic [5:0]  byte_pos;

  logic in_fired = 1'b0;
  logic out_fired = 1'b0;
  int   err_count = 0;
  int   words_in = 0;
  int   next_hold = 30;
  int   hold_left = 0;
  int   cycles = 0;
  int   send_gap = 0;
  int   send_run = 0;
  bit   send_quiet = 1'b0;
  int   pop_gap = 0;
  int   pop_run = 0;
  bit   pop_quiet = 1'b0;

  md5_hash_engine_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  always #4 clk = ~clk;

  function automatic void hash_restart();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    msg_bits = '0;
    byte_pos = '0;
  endfunction

  function automatic logic [31:0] rotate_left(logic [31:0] x, logic [4:0] n);
    return (x << n) | (x >> (6'd32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, t;
    int s, g;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (s = 0; s < 64; s++) begin
      case (s / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = s;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = 5 * s + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * s + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * s;
        end
      endcase
      t = f + a + blk_buf[g % 16] + ROUND_K[s];
      a = d;
      d = c;
      c = b;
      b = b + rotate_left(t, ROT_AMT[(s / 16) * 4 + s % 4]);
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  function automatic void put_byte(logic [7:0] v);
    blk_buf[byte_pos[5:2]][8 * byte_pos[1:0] +: 8] = v;
    byte_pos = byte_pos + 6'd1;
    if (byte_pos == 6'd0) compress_block();
  endfunction

  function automatic void digest_step(md5_pkg::md5_in_t w);
    int n, i;
    logic [63:0] len;
    md5_pkg::md5_out_t r;
    n = (w.valid_bytes > md5_pkg::MAX_BYTES) ? int'(md5_pkg::MAX_BYTES)
                                             : int'(w.valid_bytes);
    for (i = 0; i < n; i++) begin
      put_byte(w.data_word[8 * i +: 8]);
      msg_bits += 64'd8;
    end
    if (w.last_word) begin
      len = msg_bits;
      put_byte(md5_pkg::PAD_BYTE);
      while (byte_pos != md5_pkg::LEN_POS) put_byte(8'h00);
      for (i = 0; i < 8; i++) put_byte(len[8 * i +: 8]);
      for (i = 0; i < 4; i++) begin
        r.digest_word = chain[i];
        r.word_index = 2'(i);
        r.digest_last = (i == 3);
        digest_q.push_back(r);
      end
      hash_restart();
    end
  endfunction

  function automatic void check_digest(md5_pkg::md5_out_t got);
    md5_pkg::md5_out_t want;
    if (digest_q.size() == 0) begin
      $error("unexpected digest word %h", got.digest_word);
      err_count++;
    end else begin
      want = digest_q.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
        err_count++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
        err_count++;
      end
      if (got.digest_last !== want.digest_last) begin
        $error("digest_last: expected %0b, got %0b", want.digest_last, got.digest_last);
        err_count++;
      end
    end
  endfunction

  function automatic int draw_gap(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic void queue_word(logic [31:0] data, logic [2:0] nbytes, logic last);
    md5_pkg::md5_in_t w;
    w.data_word = data;
    w.valid_bytes = nbytes;
    w.last_word = last;
    msg_q.push_back(w);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fired <= 1'b0;
      out_fired <= 1'b0;
    end else begin
      in_fired <= in_push && !in_full;
      out_fired <= out_pop && !out_empty;
      if (in_push && !in_full) begin
        digest_step(in_data);
        words_in <= words_in + 1;
      end
      if (out_pop && !out_empty) check_digest(out_data);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_fired) begin
      if (in_fired) send_gap = draw_gap(send_run, send_quiet);
      if (send_gap == 0 && msg_q.size() > 0) begin
        in_data <= msg_q.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // long receiver hold-off so the input queue backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (words_in >= next_hold) begin
      hold_left <= HOLD_CYCLES;
      next_hold <= next_hold + 120;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_fired) pop_gap = draw_gap(pop_run, pop_quiet);
      if (hold_left > 0 || pop_gap > 0) begin
        out_pop <= 1'b0;
        if (hold_left == 0) pop_gap--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int count, nwords, k;
    hash_restart();

    queue_word($urandom, 3'd0, 1'b1);
    queue_word({8'hff, 24'h636261}, 3'd3, 1'b1);
    queue_word(32'hffffffff, 3'd4, 1'b1);
    queue_word(32'h00000000, 3'd4, 1'b1);
    queue_word(32'hdeadbeef, 3'd7, 1'b0);
    queue_word(32'h01234567, 3'd6, 1'b1);
    queue_word(32'hffffffaa, 3'd1, 1'b0);
    queue_word(32'hffffbbcc, 3'd2, 1'b0);
    queue_word(32'h89abcdef, 3'd5, 1'b1);
    queue_word(32'hffffffff, 3'd4, 1'b0);
    queue_word(32'h00000000, 3'd4, 1'b0);
    queue_word(32'h80000001, 3'd4, 1'b0);
    queue_word(32'hffffffff, 3'd0, 1'b1);
    queue_word(32'h12345678, 3'd0, 1'b0);
    queue_word(32'h7fffffff, 3'd2, 1'b1);

    count = 0;
    while (count < RANDOM_WORDS) begin
      nwords = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 34) : $urandom_range(0, 16);
      for (k = 0; k < nwords; k++) begin
        queue_word($urandom, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                   1'b0);
      end
      queue_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
      count += nwords + 1;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (msg_q.size() > 0 || in_push) @(posedge clk);
    while (digest_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
src/md5_pkg.sv
src/md5_front.sv
src/md5_core.sv
src/md5_hash_engine_top.sv
tb/tb_md5_hash_engine_top.sv
